[rtl/bfpp_pkg.sv]
`default_nettype none
package bfpp_pkg;

  localparam int Window     = 64;
  localparam int RingAw     = $clog2(Window);
  localparam int ScanW      = RingAw + 1;
  localparam int FillW      = 20;
  localparam int ErrW       = 21;
  localparam int SumW       = FillW + RingAw;
  localparam int ErrSumW    = 27;
  localparam int TimeW      = 31;
  localparam int QueueW     = 6;
  localparam int BbW        = 15;
  localparam int GainW      = 32;
  localparam int PitchW     = 32;
  localparam int CfgAw      = 3;
  localparam int CfgDw      = 32;
  localparam int MulBW      = ErrSumW + 1;
  localparam int ProdW      = GainW + 1 + MulBW;
  localparam int DivdW      = 54;
  localparam int DivrW      = TimeW;
  localparam int DivCntW    = $clog2(DivdW);
  localparam int AccW       = 64;
  localparam int PitchShift = 18;

  localparam logic [FillW-1:0] FillMax = {FillW{1'b1}};
  localparam logic signed [AccW-1:0] PitchLoQ48 = 64'sd1 <<< 47;
  localparam logic signed [AccW-1:0] PitchHiQ48 = 64'sd1 <<< 49;

  localparam logic [FillW-1:0]  RstFillTarget = 20'd7056;
  localparam logic [BbW-1:0]    RstBufBytes   = 15'd512;
  localparam logic [PitchW-1:0] RstPitch      = 32'h4000_0000;
  localparam logic [GainW-1:0]  RstGainP      = 32'd140737488;
  localparam logic [GainW-1:0]  RstGainI      = 32'd2815;
  localparam logic [GainW-1:0]  RstGainD      = 32'd28147;

  typedef enum logic [CfgAw-1:0] {
    RegFillTarget = 3'd0,
    RegBufBytes   = 3'd1,
    RegDefPitch   = 3'd2,
    RegGainP      = 3'd3,
    RegGainI      = 3'd4,
    RegGainD      = 3'd5
  } bfpp_reg_e;

  typedef struct packed {
    logic capture;
    logic read_head;
    logic update;
    logic scan;
    logic min_upd;
    logic prime;
    logic setup;
    logic mul_p;
    logic mul_i;
    logic mul_d;
    logic div_start;
    logic add_d;
    logic sub;
    logic clamp;
    logic out_load;
  } bfpp_cmd_t;

  typedef struct packed {
    logic playing;
    logic target_nz;
    logic scan_done;
    logic dt_pos;
    logic div_done;
  } bfpp_sts_t;

endpackage
`default_nettype wire

[rtl/bfpp_if.sv]
`default_nettype none
interface bfpp_in_if;
  logic                         valid;
  logic                         ready;
  logic [bfpp_pkg::TimeW-1:0]   time_ms;
  logic [bfpp_pkg::QueueW-1:0]  queued_buffers;
  logic                         playing;

  modport source (output valid, time_ms, queued_buffers, playing, input ready);
  modport sink   (input valid, time_ms, queued_buffers, playing, output ready);
endinterface

interface bfpp_out_if;
  logic                              valid;
  logic                              ready;
  logic [bfpp_pkg::PitchW-1:0]       pitch;
  logic                              pitch_updated;
  logic [bfpp_pkg::FillW-1:0]        fill_average;
  logic [bfpp_pkg::FillW-1:0]        fill_minimum;
  logic [bfpp_pkg::FillW-1:0]        fill_average_of_minimum;
  logic signed [bfpp_pkg::ErrSumW-1:0] error_sum;

  modport source (output valid, pitch, pitch_updated, fill_average, fill_minimum,
                  fill_average_of_minimum, error_sum, input ready);
  modport sink   (input valid, pitch, pitch_updated, fill_average, fill_minimum,
                  fill_average_of_minimum, error_sum, output ready);
endinterface
`default_nettype wire

[rtl/buffer_fill_pitch_pid_unit.sv]
// The time from input beat to result is set by the 64-entry fill ring minimum
// scan (one entry a cycle), run only while playing, and by the 54-step serial
// divider, run only with a nonzero target and a positive time step.
// One beat at a time: the next beat is taken once the result is in the output
// register. Reset clears all rings and statistics and loads the register
// defaults; pitch starts at 1.0.
`default_nettype none
module buffer_fill_pitch_pid_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bfpp_pkg::CfgAw-1:0]  cfg_idx_i,
  input  logic [bfpp_pkg::CfgDw-1:0]  cfg_wdata_i,
  bfpp_in_if.sink                     in_if,
  bfpp_out_if.source                  out_if
);

  bfpp_pkg::bfpp_cmd_t cmd;
  bfpp_pkg::bfpp_sts_t sts;

  bfpp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfpp_datapath u_dp (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .cfg_we_i                  (cfg_we_i),
    .cfg_idx_i                 (cfg_idx_i),
    .cfg_wdata_i               (cfg_wdata_i),
    .time_ms_i                 (in_if.time_ms),
    .queued_buffers_i          (in_if.queued_buffers),
    .playing_i                 (in_if.playing),
    .cmd_i                     (cmd),
    .sts_o                     (sts),
    .pitch_o                   (out_if.pitch),
    .pitch_updated_o           (out_if.pitch_updated),
    .fill_average_o            (out_if.fill_average),
    .fill_minimum_o            (out_if.fill_minimum),
    .fill_average_of_minimum_o (out_if.fill_average_of_minimum),
    .error_sum_o               (out_if.error_sum)
  );

endmodule
`default_nettype wire

[rtl/bfpp_div.sv]
`default_nettype none
module bfpp_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bfpp_pkg::DivdW-1:0]   dividend_i,
  input  logic [bfpp_pkg::DivrW-1:0]   divisor_i,
  output logic                         done_o,
  output logic [bfpp_pkg::DivdW-1:0]   quotient_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [bfpp_pkg::DivCntW-1:0]  cnt_q;
  logic [bfpp_pkg::DivdW-1:0]    quo_q;
  logic [bfpp_pkg::DivrW-1:0]    rem_q;
  logic [bfpp_pkg::DivrW-1:0]    dvs_q;
  logic [bfpp_pkg::DivrW:0]      shifted;
  logic [bfpp_pkg::DivrW:0]      diff;
  logic                          fits;

  assign shifted = {rem_q, quo_q[bfpp_pkg::DivdW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= bfpp_pkg::DivCntW'(bfpp_pkg::DivdW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[bfpp_pkg::DivrW-1:0] : shifted[bfpp_pkg::DivrW-1:0];
      quo_q <= {quo_q[bfpp_pkg::DivdW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

[rtl/bfpp_datapath.sv]
`default_nettype none
module bfpp_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bfpp_pkg::CfgAw-1:0]        cfg_idx_i,
  input  logic [bfpp_pkg::CfgDw-1:0]        cfg_wdata_i,
  input  logic [bfpp_pkg::TimeW-1:0]        time_ms_i,
  input  logic [bfpp_pkg::QueueW-1:0]       queued_buffers_i,
  input  logic                              playing_i,
  input  bfpp_pkg::bfpp_cmd_t               cmd_i,
  output bfpp_pkg::bfpp_sts_t               sts_o,
  output logic [bfpp_pkg::PitchW-1:0]       pitch_o,
  output logic                              pitch_updated_o,
  output logic [bfpp_pkg::FillW-1:0]        fill_average_o,
  output logic [bfpp_pkg::FillW-1:0]        fill_minimum_o,
  output logic [bfpp_pkg::FillW-1:0]        fill_average_of_minimum_o,
  output logic signed [bfpp_pkg::ErrSumW-1:0] error_sum_o
);

  localparam int FillW   = bfpp_pkg::FillW;
  localparam int ErrW    = bfpp_pkg::ErrW;
  localparam int SumW    = bfpp_pkg::SumW;
  localparam int ESumW   = bfpp_pkg::ErrSumW;
  localparam int RingAw  = bfpp_pkg::RingAw;
  localparam int TimeW   = bfpp_pkg::TimeW;
  localparam int GainW   = bfpp_pkg::GainW;
  localparam int MulBW   = bfpp_pkg::MulBW;
  localparam int ProdW   = bfpp_pkg::ProdW;
  localparam int AccW    = bfpp_pkg::AccW;
  localparam int DivdW   = bfpp_pkg::DivdW;
  localparam int PShift  = bfpp_pkg::PitchShift;
  localparam int PitchW  = bfpp_pkg::PitchW;
  localparam int RawW    = bfpp_pkg::QueueW + bfpp_pkg::BbW;

  logic [FillW-1:0]              target_q;
  logic [bfpp_pkg::BbW-1:0]      bb_q;
  logic [PitchW-1:0]             defp_q;
  logic [GainW-1:0]              gp_q, gi_q, gd_q;

  logic [TimeW-1:0]              t_q;
  logic [bfpp_pkg::QueueW-1:0]   queued_q;
  logic                          play_q;
  logic [FillW-1:0]              fill_q;

  logic [FillW-1:0]              fill_mem [bfpp_pkg::Window];
  logic signed [ErrW-1:0]        err_mem  [bfpp_pkg::Window];
  logic [FillW-1:0]              min_mem  [bfpp_pkg::Window];
  logic [bfpp_pkg::Window-1:0]   valid_q;
  logic [FillW-1:0]              fill_rd_q;
  logic signed [ErrW-1:0]        err_rd_q;
  logic [FillW-1:0]              min_rd_q;
  logic [RingAw-1:0]             rd_addr;

  logic [RingAw-1:0]             head_q;
  logic [bfpp_pkg::ScanW-1:0]    scnt_q;
  logic [FillW-1:0]              least_q;
  logic [SumW-1:0]               fill_total_q;
  logic [FillW-1:0]              fill_mean_q;
  logic [FillW-1:0]              fill_least_q;
  logic [SumW-1:0]               min_total_q;
  logic signed [ESumW-1:0]       err_total_q;
  logic signed [ErrW-1:0]        prev_err_q, older_err_q;
  logic [TimeW-1:0]              prev_time_q, older_time_q;
  logic [PitchW-1:0]             pitch_q;
  logic                          primed_q;

  logic signed [ErrW-1:0]        e_q;
  logic signed [ErrW:0]          ediff_q;
  logic                          dt_pos_q;
  logic [bfpp_pkg::DivrW-1:0]    dvs_q;
  logic signed [ProdW-1:0]       prod_q;
  logic signed [AccW-1:0]        acc_q;
  logic                          neg_q;

  logic [RawW-1:0]               fill_raw;
  logic signed [ErrW-1:0]        err_now;
  logic signed [TimeW:0]         dt;
  logic signed [GainW:0]         mul_a;
  logic signed [MulBW-1:0]       mul_b;
  logic signed [ProdW-1:0]       mul_p;
  logic signed [ProdW-1:0]       abs_prod;
  logic [DivdW-1:0]              quo;
  logic                          div_done;
  logic signed [AccW-1:0]        d_mag, d_val, base, prod_ext;

  assign fill_raw = RawW'(queued_q) * RawW'(bb_q);
  assign err_now  = signed'({1'b0, target_q}) - signed'({1'b0, fill_mean_q});
  assign dt       = signed'({1'b0, t_q}) - signed'({1'b0, older_time_q});
  assign rd_addr  = cmd_i.scan ? scnt_q[RingAw-1:0] : head_q;

  always_comb begin
    mul_a = signed'({1'b0, gp_q});
    mul_b = MulBW'(e_q);
    if (cmd_i.mul_i) begin
      mul_a = signed'({1'b0, gi_q});
      mul_b = MulBW'(err_total_q);
    end else if (cmd_i.mul_d) begin
      mul_a = signed'({1'b0, gd_q});
      mul_b = MulBW'(ediff_q);
    end
  end

  assign mul_p    = ProdW'(mul_a) * ProdW'(mul_b);
  assign abs_prod = prod_q[ProdW-1] ? -prod_q : prod_q;
  assign prod_ext = AccW'(prod_q);
  assign d_mag    = signed'(AccW'(quo));
  assign d_val    = !dt_pos_q ? '0 : (neg_q ? -d_mag : d_mag);
  assign base     = signed'({{(AccW - PitchW - PShift){1'b0}}, defp_q, {PShift{1'b0}}});

  bfpp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (abs_prod[DivdW-1:0]),
    .divisor_i  (dvs_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= bfpp_pkg::RstFillTarget;
      bb_q     <= bfpp_pkg::RstBufBytes;
      defp_q   <= bfpp_pkg::RstPitch;
      gp_q     <= bfpp_pkg::RstGainP;
      gi_q     <= bfpp_pkg::RstGainI;
      gd_q     <= bfpp_pkg::RstGainD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfpp_pkg::RegFillTarget: target_q <= cfg_wdata_i[FillW-1:0];
        bfpp_pkg::RegBufBytes:   bb_q     <= cfg_wdata_i[bfpp_pkg::BbW-1:0];
        bfpp_pkg::RegDefPitch:   defp_q   <= cfg_wdata_i;
        bfpp_pkg::RegGainP:      gp_q     <= cfg_wdata_i;
        bfpp_pkg::RegGainI:      gi_q     <= cfg_wdata_i;
        bfpp_pkg::RegGainD:      gd_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      head_q       <= '0;
      scnt_q       <= '0;
      fill_total_q <= '0;
      fill_mean_q  <= '0;
      fill_least_q <= '0;
      min_total_q  <= '0;
      err_total_q  <= '0;
      prev_err_q   <= '0;
      older_err_q  <= '0;
      prev_time_q  <= '0;
      older_time_q <= '0;
      pitch_q      <= bfpp_pkg::RstPitch;
      primed_q     <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        scnt_q <= '0;
      end
      if (cmd_i.update) begin
        valid_q[head_q] <= 1'b1;
        fill_total_q    <= fill_total_q - SumW'(fill_rd_q) + SumW'(fill_q);
        err_total_q     <= err_total_q - ESumW'(err_rd_q) + ESumW'(err_now);
      end
      if (cmd_i.scan && !scnt_q[RingAw]) begin
        scnt_q <= scnt_q + 1'b1;
      end
      if (cmd_i.min_upd) begin
        fill_least_q <= least_q;
        min_total_q  <= min_total_q - SumW'(min_rd_q) + SumW'(least_q);
        fill_mean_q  <= fill_total_q[SumW-1:RingAw];
        head_q       <= head_q + 1'b1;
      end
      if (cmd_i.prime && !primed_q) begin
        prev_time_q  <= t_q;
        older_time_q <= t_q;
        primed_q     <= 1'b1;
      end
      if (cmd_i.setup) begin
        older_err_q  <= prev_err_q;
        older_time_q <= prev_time_q;
        prev_err_q   <= err_now;
        prev_time_q  <= t_q;
      end
      if (cmd_i.clamp) begin
        if (acc_q < bfpp_pkg::PitchLoQ48) begin
          pitch_q <= bfpp_pkg::PitchLoQ48[PShift +: PitchW];
        end else if (acc_q > bfpp_pkg::PitchHiQ48) begin
          pitch_q <= bfpp_pkg::PitchHiQ48[PShift +: PitchW];
        end else begin
          pitch_q <= acc_q[PShift +: PitchW];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      t_q      <= time_ms_i;
      queued_q <= queued_buffers_i;
      play_q   <= playing_i;
    end
    if (cmd_i.read_head) begin
      fill_q   <= (fill_raw > RawW'(bfpp_pkg::FillMax)) ? bfpp_pkg::FillMax
                                                        : fill_raw[FillW-1:0];
      err_rd_q <= valid_q[head_q] ? err_mem[head_q] : '0;
      min_rd_q <= valid_q[head_q] ? min_mem[head_q] : '0;
    end
    if (cmd_i.read_head || (cmd_i.scan && !scnt_q[RingAw])) begin
      fill_rd_q <= valid_q[rd_addr] ? fill_mem[rd_addr] : '0;
    end
    if (cmd_i.update) begin
      fill_mem[head_q] <= fill_q;
      err_mem[head_q]  <= err_now;
    end
    if (cmd_i.min_upd) begin
      min_mem[head_q] <= least_q;
    end
    if (cmd_i.scan && (scnt_q != '0)) begin
      if ((scnt_q == bfpp_pkg::ScanW'(1)) || (fill_rd_q < least_q)) begin
        least_q <= fill_rd_q;
      end
    end
    if (cmd_i.setup) begin
      e_q      <= err_now;
      ediff_q  <= (ErrW + 1)'(err_now) - (ErrW + 1)'(older_err_q);
      dt_pos_q <= !dt[TimeW] && (dt != '0);
      dvs_q    <= dt[bfpp_pkg::DivrW-1:0];
    end
    if (cmd_i.mul_p || cmd_i.mul_i || cmd_i.mul_d) begin
      prod_q <= mul_p;
    end
    if (cmd_i.mul_i) begin
      acc_q <= prod_ext;
    end
    if (cmd_i.mul_d) begin
      acc_q <= acc_q + prod_ext;
    end
    if (cmd_i.div_start) begin
      neg_q <= prod_q[ProdW-1];
    end
    if (cmd_i.add_d) begin
      acc_q <= acc_q + d_val;
    end
    if (cmd_i.sub) begin
      acc_q <= base - acc_q;
    end
    if (cmd_i.out_load) begin
      pitch_o                   <= pitch_q;
      pitch_updated_o           <= (target_q != '0);
      fill_average_o            <= fill_mean_q;
      fill_minimum_o            <= fill_least_q;
      fill_average_of_minimum_o <= min_total_q[SumW-1:RingAw];
      error_sum_o               <= err_total_q;
    end
  end

  assign sts_o.playing   = play_q;
  assign sts_o.target_nz = (target_q != '0);
  assign sts_o.scan_done = scnt_q[RingAw];
  assign sts_o.dt_pos    = dt_pos_q;
  assign sts_o.div_done  = div_done;

endmodule
`default_nettype wire

[rtl/bfpp_ctrl.sv]
`default_nettype none
module bfpp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  input  bfpp_pkg::bfpp_sts_t  sts_i,
  output bfpp_pkg::bfpp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StRead, StUpdate, StScan, StMin, StPrime, StSetup, StMulP,
    StMulI, StMulD, StDivStart, StDivWait, StAddD, StSub, StClamp, StDone
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   load;

  assign load        = (state_q == StDone) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = (state_q == StIdle) && in_valid_i;
    cmd_o.read_head = (state_q == StRead);
    cmd_o.update    = (state_q == StUpdate);
    cmd_o.scan      = (state_q == StScan);
    cmd_o.min_upd   = (state_q == StMin);
    cmd_o.prime     = (state_q == StPrime);
    cmd_o.setup     = (state_q == StSetup);
    cmd_o.mul_p     = (state_q == StMulP);
    cmd_o.mul_i     = (state_q == StMulI);
    cmd_o.mul_d     = (state_q == StMulD);
    cmd_o.div_start = (state_q == StDivStart);
    cmd_o.add_d     = (state_q == StAddD);
    cmd_o.sub       = (state_q == StSub);
    cmd_o.clamp     = (state_q == StClamp);
    cmd_o.out_load  = load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle:     if (in_valid_i) state_q <= StRead;
        StRead: begin
          if (sts_i.playing)        state_q <= StUpdate;
          else if (sts_i.target_nz) state_q <= StPrime;
          else                      state_q <= StDone;
        end
        StUpdate:   state_q <= StScan;
        StScan:     if (sts_i.scan_done) state_q <= StMin;
        StMin:      state_q <= sts_i.target_nz ? StPrime : StDone;
        StPrime:    state_q <= StSetup;
        StSetup:    state_q <= StMulP;
        StMulP:     state_q <= StMulI;
        StMulI:     state_q <= StMulD;
        StMulD:     state_q <= sts_i.dt_pos ? StDivStart : StAddD;
        StDivStart: state_q <= StDivWait;
        StDivWait:  if (sts_i.div_done) state_q <= StAddD;
        StAddD:     state_q <= StSub;
        StSub:      state_q <= StClamp;
        StClamp:    state_q <= StDone;
        StDone:     if (load) state_q <= StIdle;
        default:    state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/bfpp_checker.sv]
`default_nettype none
module bfpp_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bfpp_in_if.sink                     in_if,
  bfpp_out_if.source                  out_if
);

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input taken again right after a beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.pitch)))
    else $error("stalled result dropped or changed");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.pitch_updated) |->
      (out_if.pitch >= 32'h2000_0000 && out_if.pitch <= 32'h8000_0000))
    else $error("pitch outside 0.5 to 2.0");

  a_min_le_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.fill_minimum <= out_if.fill_average))
    else $error("window minimum above window average");

endmodule

bind buffer_fill_pitch_pid_unit bfpp_checker u_bfpp_checker (.*);
`default_nettype wire

[tb/tb_top.sv]
module tb_top;

  typedef struct {
    logic [bfpp_pkg::TimeW-1:0]  time_ms;
    logic [bfpp_pkg::QueueW-1:0] queued;
    logic                        playing;
  } tick_t;

  typedef struct {
    logic [bfpp_pkg::PitchW-1:0]  pitch;
    logic                         updated;
    logic [bfpp_pkg::FillW-1:0]   avg;
    logic [bfpp_pkg::FillW-1:0]   least;
    logic [bfpp_pkg::FillW-1:0]   avg_min;
    logic [bfpp_pkg::ErrSumW-1:0] err_sum;
  } status_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [bfpp_pkg::CfgAw-1:0] cfg_idx_i;
  logic [bfpp_pkg::CfgDw-1:0] cfg_wdata_i;

  bfpp_in_if  in_if ();
  bfpp_out_if out_if ();

  buffer_fill_pitch_pid_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // shadow registers and statistics state
  logic [bfpp_pkg::FillW-1:0]  tgt;
  logic [bfpp_pkg::BbW-1:0]    bbytes;
  logic [bfpp_pkg::PitchW-1:0] dpitch;
  logic [bfpp_pkg::GainW-1:0]  kp, ki, kd;
  logic [bfpp_pkg::FillW-1:0]  fill_hist [bfpp_pkg::Window];
  longint                      err_hist  [bfpp_pkg::Window];
  logic [bfpp_pkg::FillW-1:0]  least_hist [bfpp_pkg::Window];
  int                head;
  longint            fill_sum, least_sum, err_acc;
  longint            mean_fill, least_fill;
  longint            prev_e, old_e, prev_t, old_t;
  logic [bfpp_pkg::PitchW-1:0] pitch_now;
  bit                pid_started;

  tick_t   ticks_pending[$];
  status_t status_due[$];
  int      errors, n_ticks, n_status, n_cfg;
  int      send_idle, recv_idle;
  longint  cycles;

  function automatic status_t advance_tick(tick_t tk);
    status_t r;
    longint fill, e, dt, d, acc, p;
    logic [bfpp_pkg::FillW-1:0] mn;
    if (tk.playing) begin
      fill = longint'(tk.queued) * longint'(bbytes);
      if (fill > longint'(bfpp_pkg::FillMax)) fill = longint'(bfpp_pkg::FillMax);
      e = longint'(tgt) - mean_fill;
      fill_sum = fill_sum - longint'(fill_hist[head]) + fill;
      fill_hist[head] = fill[bfpp_pkg::FillW-1:0];
      err_acc = err_acc - err_hist[head] + e;
      err_hist[head] = e;
      mean_fill = fill_sum / bfpp_pkg::Window;
      mn = fill_hist[0];
      for (int i = 1; i < bfpp_pkg::Window; i++) if (fill_hist[i] < mn) mn = fill_hist[i];
      least_fill = longint'(mn);
      least_sum = least_sum - longint'(least_hist[head]) + least_fill;
      least_hist[head] = mn;
      head = (head + 1) % bfpp_pkg::Window;
    end
    r.updated = 1'b0;
    if (tgt != '0) begin
      if (!pid_started) begin
        prev_t = longint'(tk.time_ms);
        old_t = prev_t;
        pid_started = 1'b1;
      end
      dt = longint'(tk.time_ms) - old_t;
      e = longint'(tgt) - mean_fill;
      d = 0;
      if (dt > 0) d = (longint'(kd) * (e - old_e)) / dt;
      acc = longint'(kp) * e + longint'(ki) * err_acc + d;
      old_e = prev_e;
      old_t = prev_t;
      prev_e = e;
      prev_t = longint'(tk.time_ms);
      p = longint'(dpitch) * (longint'(1) << bfpp_pkg::PitchShift) - acc;
      if (p < bfpp_pkg::PitchLoQ48) p = bfpp_pkg::PitchLoQ48;
      if (p > bfpp_pkg::PitchHiQ48) p = bfpp_pkg::PitchHiQ48;
      pitch_now = p[bfpp_pkg::PitchShift +: bfpp_pkg::PitchW];
      r.updated = 1'b1;
    end
    r.pitch   = pitch_now;
    r.avg     = mean_fill[bfpp_pkg::FillW-1:0];
    r.least   = least_fill[bfpp_pkg::FillW-1:0];
    r.avg_min = bfpp_pkg::FillW'(least_sum / bfpp_pkg::Window);
    r.err_sum = err_acc[bfpp_pkg::ErrSumW-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        tick_t tk;
        tk.time_ms = in_if.time_ms;
        tk.queued = in_if.queued_buffers;
        tk.playing = in_if.playing;
        status_due.push_back(advance_tick(tk));
        n_ticks++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (ticks_pending.size() == 0 || $urandom_range(99) < send_idle) begin
          in_if.valid <= 1'b0;
        end else begin
          tick_t tk;
          tk = ticks_pending.pop_front();
          in_if.valid <= 1'b1;
          in_if.time_ms <= tk.time_ms;
          in_if.queued_buffers <= tk.queued;
          in_if.playing <= tk.playing;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle);
      if (out_if.valid && out_if.ready) begin
        if (status_due.size() == 0) begin
          $error("result beat with no expectation");
          errors++;
        end else begin
          status_t x;
          x = status_due.pop_front();
          n_status++;
          if (out_if.pitch !== x.pitch) begin
            $error("pitch exp %h got %h", x.pitch, out_if.pitch); errors++;
          end
          if (out_if.pitch_updated !== x.updated) begin
            $error("pitch_updated exp %b got %b", x.updated, out_if.pitch_updated); errors++;
          end
          if (out_if.fill_average !== x.avg) begin
            $error("fill_average exp %0d got %0d", x.avg, out_if.fill_average); errors++;
          end
          if (out_if.fill_minimum !== x.least) begin
            $error("fill_minimum exp %0d got %0d", x.least, out_if.fill_minimum); errors++;
          end
          if (out_if.fill_average_of_minimum !== x.avg_min) begin
            $error("fill_average_of_minimum exp %0d got %0d", x.avg_min,
                   out_if.fill_average_of_minimum); errors++;
          end
          if (out_if.error_sum !== x.err_sum) begin
            $error("error_sum exp %h got %h", x.err_sum, out_if.error_sum); errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 4000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(bfpp_pkg::bfpp_reg_e idx, logic [bfpp_pkg::CfgDw-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      bfpp_pkg::RegFillTarget: tgt = val[bfpp_pkg::FillW-1:0];
      bfpp_pkg::RegBufBytes:   bbytes = val[bfpp_pkg::BbW-1:0];
      bfpp_pkg::RegDefPitch:   dpitch = val;
      bfpp_pkg::RegGainP:      kp = val;
      bfpp_pkg::RegGainI:      ki = val;
      bfpp_pkg::RegGainD:      kd = val;
      default: ;
    endcase
    n_cfg++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (ticks_pending.size() == 0 && !in_if.valid && status_due.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic push_tick(logic [bfpp_pkg::TimeW-1:0] t, int q, bit play);
    tick_t tk;
    tk.time_ms = t;
    tk.queued = bfpp_pkg::QueueW'(q);
    tk.playing = play;
    ticks_pending.push_back(tk);
  endtask

  function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi);
    int r;
    logic [31:0] span;
    r = $urandom_range(3);
    span = hi - lo;
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (span == 32'hFFFF_FFFF) return $urandom();
    return lo + ($urandom() % (span + 32'd1));
  endfunction

  initial begin
    logic [bfpp_pkg::TimeW-1:0] t;
    int n;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    errors = 0; n_ticks = 0; n_status = 0; n_cfg = 0; cycles = 0;
    send_idle = 34; recv_idle = 73;
    tgt = bfpp_pkg::RstFillTarget; bbytes = bfpp_pkg::RstBufBytes;
    dpitch = bfpp_pkg::RstPitch;
    kp = bfpp_pkg::RstGainP; ki = bfpp_pkg::RstGainI; kd = bfpp_pkg::RstGainD;
    for (int i = 0; i < bfpp_pkg::Window; i++) begin
      fill_hist[i] = '0; err_hist[i] = 0; least_hist[i] = '0;
    end
    head = 0; fill_sum = 0; least_sum = 0; err_acc = 0;
    mean_fill = 0; least_fill = 0; prev_e = 0; old_e = 0; prev_t = 0; old_t = 0;
    pitch_now = bfpp_pkg::RstPitch; pid_started = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: first step, stalls in time, time going back, field extremes
    push_tick(31'd0, 0, 1'b0);
    push_tick(31'd0, 48, 1'b1);
    push_tick(31'd16, 48, 1'b1);
    push_tick(31'd16, 31, 1'b1);
    push_tick(31'd5, 32, 1'b1);
    push_tick(31'd40, 0, 1'b0);
    push_tick(31'h7FFF_FFFF, 48, 1'b1);
    push_tick(31'h7FFF_FFFF, 21, 1'b1);
    push_tick(31'h4000_0000, 10, 1'b1);
    drain();
    write_reg(bfpp_pkg::RegFillTarget, 32'hFFFF_FFFF);
    write_reg(bfpp_pkg::RegBufBytes, 32'd32767);
    write_reg(bfpp_pkg::RegDefPitch, 32'h8000_0000);
    write_reg(bfpp_pkg::RegGainP, 32'hFFFF_FFFF);
    write_reg(bfpp_pkg::RegGainI, 32'hFFFF_FFFF);
    write_reg(bfpp_pkg::RegGainD, 32'hFFFF_FFFF);
    push_tick(31'd100, 48, 1'b1);
    push_tick(31'd110, 48, 1'b1);
    push_tick(31'd120, 0, 1'b1);
    drain();
    write_reg(bfpp_pkg::RegFillTarget, 32'd0);
    write_reg(bfpp_pkg::RegDefPitch, 32'd0);
    push_tick(31'd130, 48, 1'b1);
    push_tick(31'd140, 5, 1'b0);
    drain();
    write_reg(bfpp_pkg::RegFillTarget, 32'd1);
    write_reg(bfpp_pkg::RegBufBytes, 32'd0);
    write_reg(bfpp_pkg::RegGainP, 32'd0);
    write_reg(bfpp_pkg::RegGainI, 32'd0);
    write_reg(bfpp_pkg::RegGainD, 32'd0);
    push_tick(31'd150, 48, 1'b1);
    push_tick(31'd151, 1, 1'b1);
    push_tick(31'd152, 1, 1'b0);
    drain();

    t = 31'd200;
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_idle = 34; recv_idle = 73;
      end else if (ph < 6) begin
        send_idle = 73; recv_idle = 34;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      write_reg(bfpp_pkg::RegFillTarget,
                (ph % 4 == 3) ? 32'd0 : pick(32'd1, 32'hF_FFFF));
      write_reg(bfpp_pkg::RegBufBytes, (ph == 4) ? 32'd32767 : pick(32'd1, 32'd16384));
      write_reg(bfpp_pkg::RegDefPitch, pick(32'd0, 32'h8000_0000));
      write_reg(bfpp_pkg::RegGainP, ($urandom_range(1)) ? pick(32'd0, 32'hFFFF_FFFF)
                                                        : $urandom_range(300000000));
      write_reg(bfpp_pkg::RegGainI, ($urandom_range(1)) ? pick(32'd0, 32'hFFFF_FFFF)
                                                        : $urandom_range(10000));
      write_reg(bfpp_pkg::RegGainD, ($urandom_range(1)) ? pick(32'd0, 32'hFFFF_FFFF)
                                                        : $urandom_range(100000));
      n = 160 + $urandom_range(20);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(99) < 2) t = bfpp_pkg::TimeW'($urandom());
        else t = bfpp_pkg::TimeW'(t + $urandom_range(40));
        push_tick(t, $urandom_range(48), $urandom_range(99) < 85);
      end
      drain();
    end
    $display("Covered %0d ticks, %0d results, %0d register writes", n_ticks, n_status,
             n_cfg);
    $display("over reset defaults, disabled target, saturated fill and pitch limits");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
